// ===== hw/rtl/mbd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multistream block demuxer.
// Holds the parser phase type, the result word layout, result codes and flag masks.
// Has no dependencies.
package mbd_pkg;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SAMPLES,
      PH_SUBHDR,
      PH_PAYLOAD,
      PH_DRAIN,
      PH_HALT
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_SAMPLES = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_FLAGS      = 3'd1;
   localparam logic [2:0] ERR_BLOCK_SMALL = 3'd2;
   localparam logic [2:0] ERR_LENGTH     = 3'd3;
   localparam logic [2:0] ERR_SUB_SMALL  = 3'd4;

   // Flag masks of the block header's top byte.
   localparam logic [7:0] FLAG_LAST_MASK = 8'h81;
   localparam logic [7:0] FLAG_SKIP_MASK = 8'h09;
   localparam logic [7:0] FLAG_BAD_MASK  = 8'h32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [3:0]  stream_index;
      logic        frame_last;
      logic [10:0] pad_count;
      logic [31:0] sample_count;
      logic [2:0]  error_code;
   } result_type;

   // Results produced by one parsed byte, handed to the result queue.
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [7:0] data_byte,
                                              input logic [3:0] stream_index,
                                              input logic frame_last,
                                              input logic [10:0] pad_count,
                                              input logic [31:0] sample_count,
                                              input logic [2:0] error_code);
      result_type r;
      r.kind          = kind;
      r.data_byte     = data_byte;
      r.stream_index  = stream_index;
      r.frame_last    = frame_last;
      r.pad_count     = pad_count;
      r.sample_count  = sample_count;
      r.error_code    = error_code;
      return r;
   endfunction

endpackage

// ===== hw/rtl/mbd_parser.sv =====
`timescale 1ns / 1ps
// Block parser: holds the container parse state and the stream count register,
// and turns one byte into up to two result words. Depends on mbd_pkg.
module mbd_parser import mbd_pkg::*; #(
   parameter int FRAME_BYTES = 2048,
   parameter int MAX_STREAMS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data,
   input  logic       fire,
   input  logic [7:0] in_byte,
   output push_type   push
);

   localparam int FPOS_W = $clog2(FRAME_BYTES);
   localparam logic [4:0] STREAM_CAP = 5'((MAX_STREAMS < 16) ? MAX_STREAMS : 16);

   typedef struct packed {
      phase_type  phase;
      logic [3:0] cursor;
      logic       emit;
      result_type res;
   } step_type;

   phase_type         phase_ff, phase_in;
   logic [1:0]        hcnt_ff, hcnt_in;
   logic [31:0]       word_ff, word_in;
   logic [23:0]       brem_ff, brem_in;
   logic [29:0]       srem_ff, srem_in;
   logic [FPOS_W-1:0] fpos_ff, fpos_in;
   logic [3:0]        cursor_ff, cursor_in;
   logic              last_ff, last_in;
   logic              skip_ff, skip_in;
   logic [4:0]        scount_ff, scount_in;

   logic [31:0] word_new;
   logic [1:0]  hcnt_new;
   logic [4:0]  eff_streams;
   logic [16:0] pad_wide;

   function automatic result_type err_result(input logic [2:0] code);
      return make_result(KIND_ERROR, 8'h00, 4'd0, 1'b0, 11'd0, 32'd0, code);
   endfunction

   // End-of-block handling once the last subblock is done or a drain empties.
   function automatic step_type finish_fn(input logic [23:0] brem, input logic last,
                                          input logic [3:0] cursor);
      step_type s;
      s.cursor = cursor;
      s.emit   = 1'b0;
      s.res    = '0;
      if (brem == 24'd0) begin
         if (last) begin
            s.phase = PH_HALT;
            s.emit  = 1'b1;
            s.res   = make_result(KIND_END, 8'h00, 4'd0, 1'b0, 11'd0, 32'd0, ERR_NONE);
         end else begin
            s.phase = PH_HEADER;
         end
      end else if (last) begin
         s.phase = PH_DRAIN;
      end else begin
         s.phase = PH_HALT;
         s.emit  = 1'b1;
         s.res   = err_result(ERR_LENGTH);
      end
      return s;
   endfunction

   function automatic step_type next_fn(input logic [3:0] cursor, input logic [4:0] eff,
                                        input logic [23:0] brem, input logic last);
      step_type s;
      if (({1'b0, cursor} + 5'd1) >= eff) begin
         s = finish_fn(brem, last, 4'd0);
      end else begin
         s.phase  = PH_SUBHDR;
         s.cursor = cursor + 4'd1;
         s.emit   = 1'b0;
         s.res    = '0;
      end
      return s;
   endfunction

   assign word_new = {word_ff[23:0], in_byte};
   assign hcnt_new = hcnt_ff + 2'd1;
   assign pad_wide = 17'(FRAME_BYTES - 1) - 17'(fpos_ff);

   always_comb begin
      if (scount_ff == 5'd0) begin
         eff_streams = 5'd1;
      end else if (scount_ff > STREAM_CAP) begin
         eff_streams = STREAM_CAP;
      end else begin
         eff_streams = scount_ff;
      end
   end

   always_comb begin
      logic [7:0]  flags;
      logic [23:0] brem_d;
      logic [29:0] srem_d;
      logic [29:0] sub;
      logic [29:0] pay;
      logic        full;
      logic        lastnew;
      step_type    s;

      phase_in   = phase_ff;
      hcnt_in    = hcnt_ff;
      word_in    = word_ff;
      brem_in    = brem_ff;
      srem_in    = srem_ff;
      fpos_in    = fpos_ff;
      cursor_in  = cursor_ff;
      last_in    = last_ff;
      skip_in    = skip_ff;
      scount_in  = csr_wr_en ? csr_wr_data : scount_ff;
      push       = '0;
      flags      = word_new[31:24];
      brem_d     = brem_ff - 24'd1;
      srem_d     = srem_ff - 30'd1;
      sub        = word_new[31:2];
      pay        = sub - 30'd4;
      full       = (fpos_ff == FPOS_W'(FRAME_BYTES - 1));
      lastnew    = |(flags & FLAG_LAST_MASK);
      s          = '0;

      if (fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               word_in = word_new;
               hcnt_in = hcnt_new;
               if (hcnt_new == 2'd0) begin
                  last_in = lastnew;
                  skip_in = |(flags & FLAG_SKIP_MASK);
                  if ((flags & FLAG_BAD_MASK) != 8'h00) begin
                     phase_in      = PH_HALT;
                     push.count    = 2'd1;
                     push.res0     = err_result(ERR_FLAGS);
                  end else if (word_new[23:0] < 24'd4) begin
                     phase_in      = PH_HALT;
                     push.count    = 2'd1;
                     push.res0     = err_result(ERR_BLOCK_SMALL);
                  end else begin
                     brem_in = word_new[23:0] - 24'd4;
                     if (|(flags & FLAG_SKIP_MASK)) begin
                        if (word_new[23:0] == 24'd4) begin
                           s          = finish_fn(24'd0, lastnew, cursor_ff);
                           phase_in   = s.phase;
                           push.count = {1'b0, s.emit};
                           push.res0  = s.res;
                        end else begin
                           phase_in = PH_DRAIN;
                        end
                     end else if (word_new[23:0] < 24'd8) begin
                        phase_in   = PH_HALT;
                        push.count = 2'd1;
                        push.res0  = err_result(ERR_LENGTH);
                     end else begin
                        phase_in = PH_SAMPLES;
                     end
                  end
               end
            end
            PH_SAMPLES: begin
               word_in = word_new;
               hcnt_in = hcnt_new;
               brem_in = brem_d;
               if (hcnt_new == 2'd0) begin
                  cursor_in  = 4'd0;
                  phase_in   = PH_SUBHDR;
                  push.count = 2'd1;
                  push.res0  = make_result(KIND_SAMPLES, 8'h00, 4'd0, 1'b0, 11'd0,
                                           word_new, ERR_NONE);
               end
            end
            PH_SUBHDR: begin
               if (brem_ff == 24'd0) begin
                  phase_in   = PH_HALT;
                  push.count = 2'd1;
                  push.res0  = err_result(ERR_LENGTH);
               end else begin
                  brem_in = brem_d;
                  word_in = word_new;
                  hcnt_in = hcnt_new;
                  if (hcnt_new == 2'd0) begin
                     if (sub < 30'd4) begin
                        phase_in   = PH_HALT;
                        push.count = 2'd1;
                        push.res0  = err_result(ERR_SUB_SMALL);
                     end else if (pay > {6'd0, brem_d}) begin
                        phase_in   = PH_HALT;
                        push.count = 2'd1;
                        push.res0  = err_result(ERR_LENGTH);
                     end else begin
                        srem_in = pay;
                        fpos_in = '0;
                        if (pay == 30'd0) begin
                           s          = next_fn(cursor_ff, eff_streams, brem_d, last_ff);
                           phase_in   = s.phase;
                           cursor_in  = s.cursor;
                           push.count = {1'b0, s.emit};
                           push.res0  = s.res;
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               brem_in    = brem_d;
               srem_in    = srem_d;
               fpos_in    = full ? '0 : fpos_ff + FPOS_W'(1);
               push.count = 2'd1;
               push.res0  = make_result(KIND_PAYLOAD, in_byte, cursor_ff,
                                        full || (srem_d == 30'd0),
                                        ((srem_d == 30'd0) && !full) ? pad_wide[10:0] : 11'd0,
                                        32'd0, ERR_NONE);
               if (srem_d == 30'd0) begin
                  s          = next_fn(cursor_ff, eff_streams, brem_d, last_ff);
                  phase_in   = s.phase;
                  cursor_in  = s.cursor;
                  push.count = s.emit ? 2'd2 : 2'd1;
                  push.res1  = s.res;
               end
            end
            PH_DRAIN: begin
               if (brem_ff != 24'd0) begin
                  brem_in = brem_d;
               end
               if (brem_ff <= 24'd1) begin
                  s          = finish_fn(24'd0, last_ff, cursor_ff);
                  phase_in   = s.phase;
                  push.count = {1'b0, s.emit};
                  push.res0  = s.res;
               end
            end
            PH_HALT: begin
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hcnt_ff   <= 2'd0;
         word_ff   <= 32'd0;
         brem_ff   <= 24'd0;
         srem_ff   <= 30'd0;
         fpos_ff   <= '0;
         cursor_ff <= 4'd0;
         last_ff   <= 1'b0;
         skip_ff   <= 1'b0;
         scount_ff <= 5'd1;
      end else begin
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         word_ff   <= word_in;
         brem_ff   <= brem_in;
         srem_ff   <= srem_in;
         fpos_ff   <= fpos_in;
         cursor_ff <= cursor_in;
         last_ff   <= last_in;
         skip_ff   <= skip_in;
         scount_ff <= scount_in;
      end
   end

endmodule

// ===== hw/rtl/mbd_result_queue.sv =====
`timescale 1ns / 1ps
// Result queue: four-entry queue that takes up to two result words per cycle
// and presents one word a cycle on the response channel while rsp_ready is high. Depends on mbd_pkg.
module mbd_result_queue import mbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_word
);

   result_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  pop;

   // Room is raised only while two entries are free, enough for the worst-case byte.
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QPTR_W'(1)] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/multistream_block_demuxer.sv =====
`timescale 1ns / 1ps
// Multistream block demuxer top level: input byte register, block parser and result queue.
// An accepted byte waits in the input register and is parsed from there; its results enter
// the queue, which offers them on the response channel. The byte is held while room is low.
// Throughput: one byte per cycle; the four-entry result queue holds back input only
// when fewer than two entries are free. Synchronous active-high reset returns the
// parser to the block header phase, empties the queue and sets the stream count to 1.
module multistream_block_demuxer import mbd_pkg::*; #(
   parameter int FRAME_BYTES = 2048,
   parameter int MAX_STREAMS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_stream_index,
   output logic        rsp_frame_last,
   output logic [10:0] rsp_pad_count,
   output logic [31:0] rsp_sample_count,
   output logic [2:0]  rsp_error_code
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       room;
   logic       fire;
   push_type   push;
   result_type rsp_word;

   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   mbd_parser #(
      .FRAME_BYTES (FRAME_BYTES),
      .MAX_STREAMS (MAX_STREAMS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .in_byte     (in_byte_ff),
      .push        (push)
   );

   mbd_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_kind          = rsp_word.kind;
   assign rsp_data_byte     = rsp_word.data_byte;
   assign rsp_stream_index  = rsp_word.stream_index;
   assign rsp_frame_last    = rsp_word.frame_last;
   assign rsp_pad_count     = rsp_word.pad_count;
   assign rsp_sample_count  = rsp_word.sample_count;
   assign rsp_error_code    = rsp_word.error_code;

endmodule

// ===== hw/rtl/mbd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the multistream block demuxer and its bind statement.
// Depends on mbd_pkg and the top level's port list.
module mbd_checker import mbd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [3:0]  rsp_stream_index,
   input logic        rsp_frame_last,
   input logic [10:0] rsp_pad_count,
   input logic [31:0] rsp_sample_count,
   input logic [2:0]  rsp_error_code
);

   // A stalled response word stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_data_byte) && $stable(rsp_stream_index) && $stable(rsp_frame_last) &&
      $stable(rsp_pad_count) && $stable(rsp_sample_count) && $stable(rsp_error_code))
      else $error("response word changed while stalled");

   // Once an end or error word is taken, the block is halted and never answers again.
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_END || rsp_kind == KIND_ERROR)
      |=> !rsp_valid)
      else $error("response after end or error");

   // Fill counts only appear on a byte that closes a frame.
   a_pad_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD && !rsp_frame_last |-> rsp_pad_count == 11'd0)
      else $error("fill count on a byte that does not end a frame");

   // Error words carry a defined code.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |->
      (rsp_error_code == ERR_FLAGS || rsp_error_code == ERR_BLOCK_SMALL ||
       rsp_error_code == ERR_LENGTH || rsp_error_code == ERR_SUB_SMALL))
      else $error("error word with an undefined code");

   // Payload words carry no sample count or error code.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD |->
      rsp_sample_count == 32'd0 && rsp_error_code == ERR_NONE)
      else $error("payload word with stray fields");

endmodule

bind multistream_block_demuxer mbd_checker u_mbd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_stream_index  (rsp_stream_index),
   .rsp_frame_last    (rsp_frame_last),
   .rsp_pad_count     (rsp_pad_count),
   .rsp_sample_count  (rsp_sample_count),
   .rsp_error_code    (rsp_error_code)
);
